// ----- hw/rtl/keyed_running_stats_baseline_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the keyed running statistics block
// Shared implication forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYED_RUNNING_STATS_BASELINE_TOP_ASSERT_SVH
`define KEYED_RUNNING_STATS_BASELINE_TOP_ASSERT_SVH

// same-cycle implication
`define KS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ks assertion failed");

// next-cycle implication
`define KS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ks assertion failed");

`endif

// ----- hw/rtl/ks_pkg.sv -----
// ----------------------------------------------------------------------------
// ks_pkg
// Types and codes shared by the keyed running statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ks_pkg;

    typedef struct packed {
        logic        [31:0] resource_key;
        logic signed [31:0] sample_value;
    } ks_in_t;

    typedef struct packed {
        logic        [4:0]  entry_slot;
        logic        [1:0]  update_status;
        logic        [31:0] sample_count;
        logic signed [31:0] running_mean;
        logic               baseline_ready;
        logic signed [31:0] baseline_avg;
        logic        [31:0] baseline_deviation;
    } ks_out_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] count;
        logic [31:0] mean;
        logic [63:0] m2;
        logic [31:0] base_mean;
        logic [31:0] base_dev;
        logic        base_ready;
    } ks_row_t;

    localparam logic [1:0] STATUS_UPDATED = 2'd0;
    localparam logic [1:0] STATUS_OPENED  = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    localparam int          CFG_ADDR_W     = 3;
    localparam logic        CFG_IDX_WINDOW = 1'b0;
    localparam logic [15:0] WINDOW_RESET   = 16'd1000;
    localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

endpackage

// ----- hw/rtl/ks_div.sv -----
// ----------------------------------------------------------------------------
// ks_div
// Iterative restoring divider, one quotient bit per cycle, 64 / 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ks_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [6:0]  n_iter,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] q_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        fits;

    assign rem_sh = {rem_reg, q_reg[63]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign fits   = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                q_reg    <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= n_iter;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                q_reg   <= {q_reg[62:0], fits};
                rem_reg <= fits ? diff[31:0] : rem_sh[31:0];
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- hw/rtl/keyed_running_stats_baseline_top.sv -----
// ----------------------------------------------------------------------------
// keyed_running_stats_baseline_top
// Per-key Welford mean / squared-deviation tracking with baseline capture.
// ----------------------------------------------------------------------------
// One request is worked at a time. The key search reads one table row per
// cycle; the mean update runs a divide on the shared divider, then a multiply
// and an accumulate step. On the one request that captures an entry's
// baseline, if its count is at least two, a 64-bit divide of the
// squared-deviation sum and a square root follow.
`timescale 1ns / 1ps

module keyed_running_stats_baseline_top
    import ks_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ks_in_t                in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output ks_out_t               out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int UW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEARCH, ST_UPD, ST_DIV1, ST_MUL, ST_ACC, ST_DIV2, ST_SQRT, ST_DONE
    } state_t;

    ks_row_t mem [TABLE_DEPTH];
    ks_row_t rd_row_reg;
    ks_row_t wr_row;
    logic [SW-1:0] rd_addr;

    state_t state_reg, state_next;
    logic [UW-1:0] used_reg, used_next;
    logic [UW-1:0] idx_reg, idx_next;
    logic [SW-1:0] pidx_reg, pidx_next;
    logic pend_reg, pend_next;
    logic [15:0] window_reg, window_next;
    logic [31:0] key_reg, key_next;
    logic signed [31:0] sample_reg, sample_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [1:0] status_reg, status_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] mean_reg, mean_next;
    logic [63:0] m2_reg, m2_next;
    logic [31:0] bmean_reg, bmean_next;
    logic [31:0] bdev_reg, bdev_next;
    logic bready_reg, bready_next;
    logic wr_flag_reg, wr_flag_next;
    logic [31:0] ad_reg, ad_next;
    logic neg_reg, neg_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic out_valid_reg, out_valid_next;
    ks_out_t out_reg, out_next;
    logic wr_en;

    logic div_start;
    logic [6:0] div_iter;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic div_done;
    logic [63:0] div_q;

    logic [31:0] cnt_inc;
    logic signed [32:0] delta;
    logic signed [32:0] delta2;
    logic [33:0] mean_sum;
    logic [32:0] q_signed;
    logic [63:0] m2_sum;
    logic [63:0] sq_trial;
    logic cfg_wr;

    ks_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .n_iter   (div_iter),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_WINDOW);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_IDX_WINDOW) ? {16'd0, window_reg} : 32'd0;

    assign rd_addr = idx_reg[SW-1:0];

    assign wr_row = '{key: key_reg, count: cnt_reg, mean: mean_reg, m2: m2_reg,
                      base_mean: bmean_reg, base_dev: bdev_reg, base_ready: bready_reg};

    always_ff @(posedge clk)
    begin
        rd_row_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[slot_reg] <= wr_row;
        end
    end

    always_comb
    begin
        cnt_inc  = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 32'd1;
        delta    = 33'(sample_reg) - 33'($signed(mean_reg));
        q_signed = neg_reg ? -div_q[32:0] : div_q[32:0];
        mean_sum = {{2{mean_reg[31]}}, mean_reg} + {q_signed[32], q_signed};
        delta2   = 33'(sample_reg) - 33'($signed(mean_reg));
        m2_sum   = m2_reg + prod_reg;
        sq_trial = res_reg + bit_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        pidx_next      = pidx_reg;
        pend_next      = pend_reg;
        window_next    = cfg_wr ? pwdata[15:0] : window_reg;
        key_next       = key_reg;
        sample_next    = sample_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        cnt_next       = cnt_reg;
        mean_next      = mean_reg;
        m2_next        = m2_reg;
        bmean_next     = bmean_reg;
        bdev_next      = bdev_reg;
        bready_next    = bready_reg;
        wr_flag_next   = wr_flag_reg;
        ad_next        = ad_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        v_next         = v_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        out_valid_next = (out_valid_reg && out_stall);
        out_next       = out_reg;
        wr_en          = 1'b0;
        div_start      = 1'b0;
        div_iter       = 7'd32;
        div_dividend   = {ad_reg, 32'd0};
        div_divisor    = cnt_reg;
        in_stall       = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next    = in_data.resource_key;
                    sample_next = in_data.sample_value;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (pend_reg && (rd_row_reg.key == key_reg))
                begin
                    slot_next    = pidx_reg;
                    status_next  = STATUS_UPDATED;
                    cnt_next     = rd_row_reg.count;
                    mean_next    = rd_row_reg.mean;
                    m2_next      = rd_row_reg.m2;
                    bmean_next   = rd_row_reg.base_mean;
                    bdev_next    = rd_row_reg.base_dev;
                    bready_next  = rd_row_reg.base_ready;
                    wr_flag_next = 1'b1;
                    state_next   = ST_UPD;
                end
                else if (idx_reg < used_reg)
                begin
                    pidx_next = idx_reg[SW-1:0];
                    idx_next  = idx_reg + UW'(1);
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else if (used_reg < UW'(TABLE_DEPTH))
                begin
                    slot_next    = used_reg[SW-1:0];
                    used_next    = used_reg + UW'(1);
                    status_next  = STATUS_OPENED;
                    cnt_next     = '0;
                    mean_next    = '0;
                    m2_next      = '0;
                    bmean_next   = '0;
                    bdev_next    = '0;
                    bready_next  = 1'b0;
                    wr_flag_next = 1'b1;
                    state_next   = ST_UPD;
                end
                else
                begin
                    slot_next    = '0;
                    status_next  = STATUS_DROPPED;
                    cnt_next     = '0;
                    mean_next    = '0;
                    bready_next  = 1'b0;
                    wr_flag_next = 1'b0;
                    state_next   = ST_DONE;
                end
            end
            ST_UPD:
            begin
                cnt_next     = cnt_inc;
                neg_next     = delta[32];
                ad_next      = delta[32] ? 32'(-delta) : delta[31:0];
                div_start    = 1'b1;
                div_iter     = 7'd32;
                div_dividend = {(delta[32] ? 32'(-delta) : delta[31:0]), 32'd0};
                div_divisor  = cnt_inc;
                state_next   = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    mean_next  = mean_sum[31:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = 64'(ad_reg) *
                             64'(delta2[32] ? 32'(-delta2) : delta2[31:0]);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                m2_next = (m2_sum < prod_reg) ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum;
                state_next = ST_DONE;
                if (!bready_reg && (cnt_reg >= 32'(window_reg)))
                begin
                    bready_next = 1'b1;
                    bmean_next  = mean_reg;
                    bdev_next   = '0;
                    if (cnt_reg >= 32'd2)
                    begin
                        div_start    = 1'b1;
                        div_iter     = 7'd64;
                        div_dividend = (m2_sum < prod_reg) ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum;
                        div_divisor  = cnt_reg - 32'd1;
                        state_next   = ST_DIV2;
                    end
                end
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    v_next     = div_q;
                    res_next   = '0;
                    bit_next   = 64'd1 << 62;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (v_reg >= sq_trial)
                begin
                    v_next   = v_reg - sq_trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == 64'd1)
                begin
                    bdev_next  = res_next[31:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    wr_en          = wr_flag_reg;
                    out_valid_next = 1'b1;
                    out_next.entry_slot         = 5'(slot_reg);
                    out_next.update_status      = status_reg;
                    out_next.sample_count       = cnt_reg;
                    out_next.running_mean       = mean_reg;
                    out_next.baseline_ready     = bready_reg;
                    out_next.baseline_avg       = bready_reg ? bmean_reg : 32'd0;
                    out_next.baseline_deviation = bready_reg ? bdev_reg : 32'd0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            idx_reg       <= '0;
            pidx_reg      <= '0;
            pend_reg      <= 1'b0;
            window_reg    <= WINDOW_RESET;
            key_reg       <= '0;
            sample_reg    <= '0;
            slot_reg      <= '0;
            status_reg    <= STATUS_UPDATED;
            cnt_reg       <= '0;
            mean_reg      <= '0;
            m2_reg        <= '0;
            bmean_reg     <= '0;
            bdev_reg      <= '0;
            bready_reg    <= 1'b0;
            wr_flag_reg   <= 1'b0;
            ad_reg        <= '0;
            neg_reg       <= 1'b0;
            prod_reg      <= '0;
            v_reg         <= '0;
            res_reg       <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            idx_reg       <= idx_next;
            pidx_reg      <= pidx_next;
            pend_reg      <= pend_next;
            window_reg    <= window_next;
            key_reg       <= key_next;
            sample_reg    <= sample_next;
            slot_reg      <= slot_next;
            status_reg    <= status_next;
            cnt_reg       <= cnt_next;
            mean_reg      <= mean_next;
            m2_reg        <= m2_next;
            bmean_reg     <= bmean_next;
            bdev_reg      <= bdev_next;
            bready_reg    <= bready_next;
            wr_flag_reg   <= wr_flag_next;
            ad_reg        <= ad_next;
            neg_reg       <= neg_next;
            prod_reg      <= prod_next;
            v_reg         <= v_next;
            res_reg       <= res_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- hw/rtl/ks_checker.sv -----
// ----------------------------------------------------------------------------
// ks_checker
// Port-level checks on the result channel of the statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keyed_running_stats_baseline_top_assert.svh"

module ks_checker
    import ks_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    out_valid,
    input logic    out_stall,
    input ks_out_t out_data
);

    `KS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    `KS_ASSERT_IMP(a_drop_zero, out_valid && (out_data.update_status == STATUS_DROPPED), (out_data.entry_slot == 5'd0) && (out_data.sample_count == 32'd0) && !out_data.baseline_ready)
    `KS_ASSERT_IMP(a_base_masked, out_valid && !out_data.baseline_ready, (out_data.baseline_avg == 32'd0) && (out_data.baseline_deviation == 32'd0))
    `KS_ASSERT_IMP(a_count_live, out_valid && (out_data.update_status != STATUS_DROPPED), out_data.sample_count != 32'd0)
    `KS_ASSERT_IMP(a_status_code, out_valid, (out_data.update_status == STATUS_UPDATED) || (out_data.update_status == STATUS_OPENED) || (out_data.update_status == STATUS_DROPPED))

endmodule

bind keyed_running_stats_baseline_top ks_checker u_ks_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ----- bench/tb_keyed_running_stats_baseline_top.sv -----
// ----------------------------------------------------------------------------
// Keyed running statistics testbench
// Drives keyed Q16.16 samples through the valid/stall request channel and
// checks every result against an in-bench Welford table model, with random
// gaps and stalls on both sides and baseline window changes between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keyed_running_stats_baseline_top;
    import ks_pkg::*;

    localparam int DEPTH = 32;
    localparam int N_KEYS = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    ks_in_t                in_data;
    logic                  out_valid;
    logic                  out_stall;
    ks_out_t               out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    keyed_running_stats_baseline_top #(.TABLE_DEPTH(DEPTH)) dut (.*);

    // shadow table
    logic [31:0] tbl_key [DEPTH];
    logic [31:0] tbl_count [DEPTH];
    longint      tbl_mean [DEPTH];
    logic [63:0] tbl_m2 [DEPTH];
    logic [31:0] tbl_base_mean [DEPTH];
    logic [31:0] tbl_base_dev [DEPTH];
    logic        tbl_ready [DEPTH];
    int          tbl_used;
    logic [15:0] window;

    ks_out_t     stats_q[$];
    ks_out_t     typed_stats[int];
    int          n_sent;
    int          n_accepted;
    int          n_errors;
    int          stall_left;
    logic        calm;
    logic [31:0] key_pool [N_KEYS];

    typedef struct {
        logic [31:0] key;
        logic [31:0] sample;
        logic        typed;
        ks_out_t     stats;
    } row_t;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [31:0] isqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res[31:0];
    endfunction

    function automatic ks_out_t welford_update(ks_in_t x);
        ks_out_t     r;
        int          s;
        logic        hit;
        longint      smp;
        longint      n;
        longint      d;
        longint      d2;
        logic [63:0] ad;
        logic [63:0] ad2;
        logic [63:0] prod;
        logic [64:0] acc;
        r = '0;
        hit = 1'b0;
        s = 0;
        smp = longint'(x.sample_value);
        for (int i = 0; i < tbl_used; i++)
        begin
            if (!hit && tbl_key[i] == x.resource_key)
            begin
                s = i;
                hit = 1'b1;
            end
        end
        r.update_status = STATUS_UPDATED;
        if (!hit)
        begin
            if (tbl_used >= DEPTH)
            begin
                r.update_status = STATUS_DROPPED;
                return r;
            end
            s = tbl_used;
            tbl_used++;
            tbl_key[s] = x.resource_key;
            tbl_count[s] = 0;
            tbl_mean[s] = 0;
            tbl_m2[s] = 0;
            tbl_base_mean[s] = 0;
            tbl_base_dev[s] = 0;
            tbl_ready[s] = 1'b0;
            r.update_status = STATUS_OPENED;
        end
        if (tbl_count[s] != COUNT_MAX)
            tbl_count[s]++;
        n = longint'({32'd0, tbl_count[s]});
        d = smp - tbl_mean[s];
        tbl_mean[s] = tbl_mean[s] + d / n;
        d2 = smp - tbl_mean[s];
        ad = (d < 0) ? -d : d;
        ad2 = (d2 < 0) ? -d2 : d2;
        prod = ad * ad2;
        acc = {1'b0, tbl_m2[s]} + {1'b0, prod};
        tbl_m2[s] = acc[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
        if (!tbl_ready[s] && tbl_count[s] >= {16'd0, window})
        begin
            tbl_base_mean[s] = tbl_mean[s][31:0];
            tbl_base_dev[s] = (tbl_count[s] >= 2)
                ? isqrt(tbl_m2[s] / ({32'd0, tbl_count[s]} - 64'd1)) : 32'd0;
            tbl_ready[s] = 1'b1;
        end
        r.entry_slot = s[4:0];
        r.sample_count = tbl_count[s];
        r.running_mean = tbl_mean[s][31:0];
        r.baseline_ready = tbl_ready[s];
        r.baseline_avg = tbl_ready[s] ? tbl_base_mean[s] : 32'd0;
        r.baseline_deviation = tbl_ready[s] ? tbl_base_dev[s] : 32'd0;
        return r;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch result %0d %s: got %h want %h", n_accepted, field, got, want);
        n_errors++;
    endtask

    // input acceptance and result checking
    always @(posedge clk)
    begin
        ks_out_t r;
        ks_out_t w;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                r = welford_update(in_data);
                if (typed_stats.exists(stats_q.size() + n_accepted))
                    r = typed_stats[stats_q.size() + n_accepted];
                stats_q.push_back(r);
            end
            if (out_valid && !out_stall)
            begin
                if (stats_q.size() == 0)
                begin
                    report("unexpected entry_slot", 32'(out_data.entry_slot), 32'd0);
                end
                else
                begin
                    w = stats_q.pop_front();
                    if (out_data.entry_slot !== w.entry_slot)
                        report("entry_slot", out_data.entry_slot, w.entry_slot);
                    if (out_data.update_status !== w.update_status)
                        report("update_status", out_data.update_status, w.update_status);
                    if (out_data.sample_count !== w.sample_count)
                        report("sample_count", out_data.sample_count, w.sample_count);
                    if (out_data.running_mean !== w.running_mean)
                        report("running_mean", out_data.running_mean, w.running_mean);
                    if (out_data.baseline_ready !== w.baseline_ready)
                        report("baseline_ready", out_data.baseline_ready, w.baseline_ready);
                    if (out_data.baseline_avg !== w.baseline_avg)
                        report("baseline_avg", out_data.baseline_avg, w.baseline_avg);
                    if (out_data.baseline_deviation !== w.baseline_deviation)
                        report("baseline_deviation", out_data.baseline_deviation,
                               w.baseline_deviation);
                end
                n_accepted++;
            end
        end
    end

    // result stall
    always @(posedge clk)
    begin
        int p;
        if (calm)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            p = $urandom_range(99);
            out_stall <= (p >= 70);
            if (p >= 95)
                stall_left <= $urandom_range(100, 30);
            else if (p >= 70)
                stall_left <= $urandom_range(2, 0);
        end
    end

    task automatic send(logic [31:0] key, logic [31:0] sample);
        int p;
        in_data <= '{resource_key: key, sample_value: sample};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_sent++;
        p = $urandom_range(99);
        if (!calm && p >= 60)
        begin
            in_valid <= 1'b0;
            repeat ((p >= 95) ? $urandom_range(80, 20) : $urandom_range(4, 1))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (stats_q.size() != 0 || n_accepted < n_sent)
            @(posedge clk);
        repeat (250)
            @(posedge clk);
    endtask

    task automatic write_window(logic [15:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'({CFG_IDX_WINDOW, 2'b00});
        pwdata <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        window = v;
    endtask

    task automatic random_phase(int count);
        logic [31:0] key;
        logic [31:0] centre;
        logic [31:0] sample;
        int          p;
        for (int i = 0; i < count; i++)
        begin
            p = $urandom_range(99);
            key = (p < 85) ? key_pool[$urandom_range(N_KEYS - 1)] : $urandom;
            centre = key * 32'h0001_3579;
            p = $urandom_range(99);
            if (p < 70)
                sample = centre + $urandom_range(32'h0004_0000) - 32'h0002_0000;
            else if (p < 90)
                sample = $urandom;
            else
                sample = (p < 95) ? 32'h7FFF_FFFF : 32'h8000_0000;
            send(key, sample);
        end
    endtask

    initial
    begin
        row_t rows[$];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        stall_left = 0;
        n_sent = 0;
        n_accepted = 0;
        n_errors = 0;
        tbl_used = 0;
        window = WINDOW_RESET;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < N_KEYS; i++)
            key_pool[i] = $urandom;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero window: baseline on first sample
        write_window(16'd0);
        rows.push_back('{32'h0000_0000, 32'h7FFF_FFFF, 1'b1,
            '{5'd0, STATUS_OPENED, 32'd1, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'd0}});
        rows.push_back('{32'hFFFF_FFFF, 32'h8000_0000, 1'b1,
            '{5'd1, STATUS_OPENED, 32'd1, 32'h8000_0000, 1'b1, 32'h8000_0000, 32'd0}});
        rows.push_back('{32'h0000_0000, 32'h8000_0000, 1'b0, '0});
        rows.push_back('{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0});
        rows.push_back('{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0});
        rows.push_back('{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0});
        foreach (rows[i])
        begin
            if (rows[i].typed)
                typed_stats[n_sent] = rows[i].stats;
            send(rows[i].key, rows[i].sample);
        end
        drain();
        rows = {};
        write_window(16'd2);
        rows.push_back('{32'h5555_AAAA, 32'h0001_0000, 1'b1,
            '{5'd2, STATUS_OPENED, 32'd1, 32'h0001_0000, 1'b0, 32'd0, 32'd0}});
        rows.push_back('{32'h5555_AAAA, 32'h0003_0000, 1'b0, '0});
        rows.push_back('{32'h5555_AAAA, 32'hFFFF_0000, 1'b0, '0});
        rows.push_back('{32'hAAAA_5555, 32'h8000_0000, 1'b0, '0});
        rows.push_back('{32'hAAAA_5555, 32'h7FFF_FFFF, 1'b0, '0});
        rows.push_back('{32'hAAAA_5555, 32'h7FFF_FFFF, 1'b0, '0});
        foreach (rows[i])
        begin
            if (rows[i].typed)
                typed_stats[n_sent] = rows[i].stats;
            send(rows[i].key, rows[i].sample);
        end
        drain();

        write_window(16'hFFFF);
        random_phase(250);
        drain();
        write_window(16'd25);
        random_phase(250);
        drain();
        calm = 1'b1;
        write_window(16'd3);
        random_phase(150);
        drain();
        calm = 1'b0;
        write_window(WINDOW_RESET);
        random_phase(250);
        drain();
        write_window(16'd0);
        random_phase(230);
        drain();

        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
